### src/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared widths, statistic codes and controller/datapath interface types for
// the image statistics accumulator.
// ----------------------------------------------------------------------------
package isa_pkg;

  localparam int MAX_PIXELS_LOG2 = 20;

  // accumulator widths
  localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
  localparam int PIX_W  = 17;
  localparam int ISUM_W = PIX_W + MAX_PIXELS_LOG2;
  localparam int ISQ_W  = 32 + MAX_PIXELS_LOG2;
  localparam int CSUM_W = 8 + MAX_PIXELS_LOG2;
  localparam int PSUM_W = 16 + MAX_PIXELS_LOG2;

  // result arithmetic widths
  localparam int MA_W   = ISQ_W;
  localparam int MB_W   = ISUM_W;
  localparam int MP_W   = MA_W + MB_W;
  localparam int DIFF_W = MP_W + 1;
  localparam int N2_W   = 2 * CNT_W;
  localparam int FRAC_W = 16;
  localparam int NS_W   = DIFF_W + 2 * FRAC_W;
  localparam int NM_W   = NS_W - 1;
  localparam int DEN_W  = N2_W + 4;
  localparam int Q_W    = 64;
  localparam int DCNT_W = $clog2(NM_W + 1);
  localparam int VAL_W  = 48;
  localparam int IDX_W  = 5;

  // statistic indexes
  localparam logic [IDX_W-1:0] STAT_COUNT  = 5'd0;
  localparam logic [IDX_W-1:0] STAT_IMIN   = 5'd1;
  localparam logic [IDX_W-1:0] STAT_IMAX   = 5'd2;
  localparam logic [IDX_W-1:0] STAT_IMEAN  = 5'd3;
  localparam logic [IDX_W-1:0] STAT_ISTD   = 5'd4;
  localparam logic [IDX_W-1:0] STAT_CMIN0  = 5'd5;
  localparam logic [IDX_W-1:0] STAT_CMAX0  = 5'd8;
  localparam logic [IDX_W-1:0] STAT_CMEAN0 = 5'd11;
  localparam logic [IDX_W-1:0] STAT_COV0   = 5'd14;
  localparam logic [IDX_W-1:0] STAT_LAST   = 5'd19;

  // multiplier operand selects
  localparam logic [2:0] MS_NS2 = 3'd0;  // n * square sum
  localparam logic [2:0] MS_SSQ = 3'd1;  // |sum| * |sum|
  localparam logic [2:0] MS_NN  = 3'd2;  // n * n
  localparam logic [2:0] MS_NP  = 3'd3;  // n * product sum
  localparam logic [2:0] MS_AB  = 3'd4;  // channel sum * channel sum

  // output value selects
  localparam logic [1:0] VS_COUNT = 2'd0;
  localparam logic [1:0] VS_QUOT  = 2'd1;
  localparam logic [1:0] VS_ROOT  = 2'd2;
  localparam logic [1:0] VS_CHAN  = 2'd3;

  // channel pairs of the product sums: rr, rg, rb, gg, gb, bb
  function automatic logic [1:0] prod_a(input int i);
    logic [1:0] r;
    case (i)
      0, 1, 2: r = 2'd0;
      3, 4:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prod_b(input int i);
    logic [1:0] r;
    case (i)
      0:       r = 2'd0;
      1, 3:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic             pix_accept;
    logic             frame_start;
    logic             mul_start;
    logic [2:0]       mul_sel;
    logic             lat_t1;
    logic             lat_diff;
    logic             lat_n2;
    logic             div_start;
    logic             sqrt_start;
    logic             out_load;
    logic [1:0]       val_sel;
    logic [IDX_W-1:0] stat_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } dp_stat_t;

endpackage

### src/isa_datapath.sv
// ----------------------------------------------------------------------------
// isa_datapath
// Pixel accumulators, shift-add multiplier, restoring divider, bit-pair
// square root and the output register.
// ----------------------------------------------------------------------------
module isa_datapath import isa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    cfg_valid,
  input  logic                    cfg_data,
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  input  logic signed [15:0]      scalar_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [IDX_W-1:0]        stat_index,
  output logic signed [VAL_W-1:0] stat_value,
  output logic                    last_stat
);

  logic                     mode;
  logic [CNT_W-1:0]         cnt;
  logic signed [ISUM_W-1:0] isum;
  logic [ISQ_W-1:0]         isq;
  logic signed [PIX_W-1:0]  imin, imax;
  logic [7:0]               cmin [3];
  logic [7:0]               cmax [3];
  logic [CSUM_W-1:0]        csum [3];
  logic [PSUM_W-1:0]        psum [6];

  logic [CNT_W-1:0]         cnt_b;
  logic signed [ISUM_W-1:0] isum_b;
  logic [ISQ_W-1:0]         isq_b;
  logic signed [PIX_W-1:0]  imin_b, imax_b;
  logic [7:0]               cmin_b [3];
  logic [7:0]               cmax_b [3];
  logic [CSUM_W-1:0]        csum_b [3];
  logic [PSUM_W-1:0]        psum_b [6];

  logic [7:0]               ch [3];
  logic [9:0]               rgb_sum;
  logic signed [PIX_W-1:0]  x;
  logic [15:0]              x_mag;
  logic [31:0]              x_sq;

  assign ch[0]   = red;
  assign ch[1]   = green;
  assign ch[2]   = blue;
  assign rgb_sum = 10'(red) + 10'(green) + 10'(blue);
  assign x       = mode ? PIX_W'(scalar_value) : signed'(PIX_W'(rgb_sum));
  assign x_mag   = x[PIX_W-1] ? 16'(-x) : 16'(x);
  assign x_sq    = x_mag * x_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
  end

  // the first beat of a frame starts from a clean slate
  always_comb begin
    cnt_b  = cmd.frame_start ? '0 : cnt;
    isum_b = cmd.frame_start ? '0 : isum;
    isq_b  = cmd.frame_start ? '0 : isq;
    imin_b = cmd.frame_start ? x : imin;
    imax_b = cmd.frame_start ? x : imax;
    for (int i = 0; i < 3; i++) begin
      cmin_b[i] = cmd.frame_start ? ch[i] : cmin[i];
      cmax_b[i] = cmd.frame_start ? ch[i] : cmax[i];
      csum_b[i] = cmd.frame_start ? '0 : csum[i];
    end
    for (int i = 0; i < 6; i++) begin
      psum_b[i] = cmd.frame_start ? '0 : psum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_accept && !cnt_b[CNT_W-1]) begin
      cnt  <= cnt_b + CNT_W'(1);
      isum <= isum_b + ISUM_W'(x);
      isq  <= isq_b + ISQ_W'(x_sq);
      imin <= (x < imin_b) ? x : imin_b;
      imax <= (x > imax_b) ? x : imax_b;
      for (int i = 0; i < 3; i++) begin
        cmin[i] <= (ch[i] < cmin_b[i]) ? ch[i] : cmin_b[i];
        cmax[i] <= (ch[i] > cmax_b[i]) ? ch[i] : cmax_b[i];
        csum[i] <= csum_b[i] + CSUM_W'(ch[i]);
      end
      for (int i = 0; i < 6; i++) begin
        psum[i] <= psum_b[i]
                 + PSUM_W'({8'b0, ch[prod_a(i)]} * {8'b0, ch[prod_b(i)]});
      end
    end
  end

  // operand selection by statistic index
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  k_cov, k_mean, k_chan;
  logic [ISUM_W-1:0] s1_mag;
  logic [PSUM_W-1:0] p_sel;
  logic [CSUM_W-1:0] ca_sel, cb_sel, cm_sel;
  logic [7:0]        chan_sel;

  assign k      = cmd.stat_idx;
  assign k_cov  = k - STAT_COV0;
  assign k_mean = k - STAT_CMEAN0;
  assign k_chan = k - STAT_CMIN0;
  assign s1_mag = isum[ISUM_W-1] ? ISUM_W'(-isum) : ISUM_W'(isum);

  always_comb begin
    p_sel    = '0;
    ca_sel   = '0;
    cb_sel   = '0;
    cm_sel   = '0;
    chan_sel = '0;
    for (int i = 0; i < 6; i++) begin
      if (k_cov[2:0] == 3'(i)) begin
        p_sel  = psum[i];
        ca_sel = csum[prod_a(i)];
        cb_sel = csum[prod_b(i)];
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (k_mean[1:0] == 2'(i)) begin
        cm_sel = csum[i];
      end
      if (k_chan == IDX_W'(i)) begin
        chan_sel = cmin[i];
      end
      if (k_chan == IDX_W'(i + 3)) begin
        chan_sel = cmax[i];
      end
    end
  end

  // shift-add multiplier, one multiplier bit per cycle
  logic [MA_W-1:0] ma_in;
  logic [MB_W-1:0] mb_in;
  logic [MP_W-1:0] ma_sh, mp;
  logic [MB_W-1:0] mb;

  always_comb begin
    case (cmd.mul_sel)
      MS_NS2: begin ma_in = isq;            mb_in = MB_W'(cnt);    end
      MS_SSQ: begin ma_in = MA_W'(s1_mag);  mb_in = s1_mag;        end
      MS_NN:  begin ma_in = MA_W'(cnt);     mb_in = MB_W'(cnt);    end
      MS_NP:  begin ma_in = MA_W'(p_sel);   mb_in = MB_W'(cnt);    end
      MS_AB:  begin ma_in = MA_W'(ca_sel);  mb_in = MB_W'(cb_sel); end
      default: begin ma_in = '0;            mb_in = '0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mb <= '0;
    end else if (cmd.mul_start) begin
      mb <= mb_in;
    end else if (|mb) begin
      mb <= mb >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_sh <= MP_W'(ma_in);
      mp    <= '0;
    end else if (|mb) begin
      if (mb[0]) begin
        mp <= mp + ma_sh;
      end
      ma_sh <= ma_sh << 1;
    end
  end

  logic [MP_W-1:0]          t1;
  logic signed [DIFF_W-1:0] diff;
  logic [N2_W-1:0]          n2;

  always_ff @(posedge clk) begin
    if (cmd.lat_t1) begin
      t1 <= mp;
    end
    if (cmd.lat_diff) begin
      diff <= signed'(DIFF_W'(t1)) - signed'(DIFF_W'(mp));
    end
    if (cmd.lat_n2) begin
      n2 <= mp[N2_W-1:0];
    end
  end

  // divider operands
  logic signed [NS_W-1:0] num_s, num_abs;
  logic [DEN_W-1:0]       den, dv, dvn, dv2n2;

  assign dv    = mode ? DEN_W'(1) : DEN_W'(3);
  assign dvn   = mode ? DEN_W'(cnt) : DEN_W'(cnt) + (DEN_W'(cnt) << 1);
  assign dv2n2 = mode ? DEN_W'(n2) : (DEN_W'(n2) << 3) + DEN_W'(n2);

  always_comb begin
    if (k == STAT_IMIN) begin
      num_s = NS_W'(imin) <<< FRAC_W;
      den   = dv;
    end else if (k == STAT_IMAX) begin
      num_s = NS_W'(imax) <<< FRAC_W;
      den   = dv;
    end else if (k == STAT_ISTD) begin
      num_s = NS_W'(diff) <<< (2 * FRAC_W);
      den   = dv2n2;
    end else if (k inside {[STAT_COV0:STAT_LAST]}) begin
      num_s = NS_W'(diff) <<< FRAC_W;
      den   = DEN_W'(n2);
    end else if (!mode && (k inside {[STAT_CMEAN0:STAT_COV0-1]})) begin
      num_s = signed'(NS_W'(cm_sel) << FRAC_W);
      den   = DEN_W'(cnt);
    end else begin
      // intensity mean, and the channel means in scalar mode
      num_s = NS_W'(isum) <<< FRAC_W;
      den   = dvn;
    end
  end

  assign num_abs = num_s[NS_W-1] ? -num_s : num_s;

  // restoring divider on the magnitude, floor fixed up at the end
  logic [NM_W-1:0]   dsh;
  logic [DEN_W-1:0]  rem, dden;
  logic [Q_W-1:0]    quo, div_res;
  logic              dneg, div_busy;
  logic [DCNT_W-1:0] dcnt;
  logic [DEN_W:0]    r2, r2_sub;
  logic              ge;

  assign r2      = {rem, dsh[NM_W-1]};
  assign r2_sub  = r2 - {1'b0, dden};
  assign ge      = (r2 >= {1'b0, dden});
  assign div_res = dneg ? -(quo + Q_W'(|rem)) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && dcnt == DCNT_W'(NM_W - 1)) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dsh  <= num_abs[NM_W-1:0];
      rem  <= '0;
      quo  <= '0;
      dneg <= num_s[NS_W-1];
      dden <= den;
      dcnt <= '0;
    end else if (div_busy) begin
      dsh  <= dsh << 1;
      rem  <= ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
      quo  <= {quo[Q_W-2:0], ge};
      dcnt <= dcnt + DCNT_W'(1);
    end
  end

  // square root, one result bit per cycle
  logic [Q_W-1:0] sx, sr, sbit, st;
  logic           sqrt_busy;

  assign st = sr + sbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_busy <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sqrt_busy <= 1'b1;
    end else if (sqrt_busy && sbit[0]) begin
      sqrt_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      // a negative variance reads as zero
      sx   <= div_res[Q_W-1] ? '0 : div_res;
      sr   <= '0;
      sbit <= Q_W'(1) << (Q_W - 2);
    end else if (sqrt_busy) begin
      if (sx >= st) begin
        sx <= sx - st;
        sr <= (sr >> 1) + sbit;
      end else begin
        sr <= sr >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  // output register
  logic [VAL_W-1:0] val;

  always_comb begin
    case (cmd.val_sel)
      VS_COUNT: val = VAL_W'({cnt, FRAC_W'(0)});
      VS_QUOT:  val = div_res[VAL_W-1:0];
      VS_ROOT:  val = sr[VAL_W-1:0];
      VS_CHAN:  val = mode ? '0 : VAL_W'({chan_sel, FRAC_W'(0)});
      default:  val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      stat_index <= k;
      stat_value <= signed'(val);
      last_stat  <= (k == STAT_LAST);
    end
  end

  assign stat.mode      = mode;
  assign stat.mul_busy  = |mb;
  assign stat.div_busy  = div_busy;
  assign stat.sqrt_busy = sqrt_busy;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

### src/isa_ctrl.sv
// ----------------------------------------------------------------------------
// isa_ctrl
// Sequencer: accepts pixels while idle, then steps the shared multiplier,
// divider and square root through the twenty statistics of a frame.
// ----------------------------------------------------------------------------
module isa_ctrl import isa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     last_pixel,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_M_NS2  = 5'd1;
  localparam logic [4:0] ST_W_NS2  = 5'd2;
  localparam logic [4:0] ST_M_SSQ  = 5'd3;
  localparam logic [4:0] ST_W_SSQ  = 5'd4;
  localparam logic [4:0] ST_M_NN   = 5'd5;
  localparam logic [4:0] ST_W_NN   = 5'd6;
  localparam logic [4:0] ST_STAT   = 5'd7;
  localparam logic [4:0] ST_M_NP   = 5'd8;
  localparam logic [4:0] ST_W_NP   = 5'd9;
  localparam logic [4:0] ST_M_AB   = 5'd10;
  localparam logic [4:0] ST_W_AB   = 5'd11;
  localparam logic [4:0] ST_DIV_GO = 5'd12;
  localparam logic [4:0] ST_DIV_W  = 5'd13;
  localparam logic [4:0] ST_SQ_GO  = 5'd14;
  localparam logic [4:0] ST_SQ_W   = 5'd15;
  localparam logic [4:0] ST_EMIT   = 5'd16;

  logic [4:0]       state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic             first_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      k             <= '0;
      first_pending <= 1'b1;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (cmd.pix_accept) begin
        first_pending <= last_pixel;
      end
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.stat_idx = k;
    state_next   = state;
    k_next       = k;
    in_ready     = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.pix_accept  = 1'b1;
          cmd.frame_start = first_pending;
          if (last_pixel) begin
            state_next = ST_M_NS2;
          end
        end
      end
      ST_M_NS2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_NS2;
        state_next    = ST_W_NS2;
      end
      ST_W_NS2: begin
        if (!stat.mul_busy) begin
          cmd.lat_t1 = 1'b1;
          state_next = ST_M_SSQ;
        end
      end
      ST_M_SSQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_SSQ;
        state_next    = ST_W_SSQ;
      end
      ST_W_SSQ: begin
        if (!stat.mul_busy) begin
          cmd.lat_diff = 1'b1;
          state_next   = ST_M_NN;
        end
      end
      ST_M_NN: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_NN;
        state_next    = ST_W_NN;
      end
      ST_W_NN: begin
        if (!stat.mul_busy) begin
          cmd.lat_n2 = 1'b1;
          k_next     = STAT_COUNT;
          state_next = ST_STAT;
        end
      end
      ST_STAT: begin
        if (k == STAT_COUNT || (k inside {[STAT_CMIN0:STAT_CMEAN0-1]})) begin
          state_next = ST_EMIT;
        end else if (!stat.mode && k >= STAT_COV0) begin
          state_next = ST_M_NP;
        end else begin
          state_next = ST_DIV_GO;
        end
      end
      // rgb covariance: n * product sum minus the product of the two channel sums
      ST_M_NP: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_NP;
        state_next    = ST_W_NP;
      end
      ST_W_NP: begin
        if (!stat.mul_busy) begin
          cmd.lat_t1 = 1'b1;
          state_next = ST_M_AB;
        end
      end
      ST_M_AB: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_AB;
        state_next    = ST_W_AB;
      end
      ST_W_AB: begin
        if (!stat.mul_busy) begin
          cmd.lat_diff = 1'b1;
          state_next   = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (!stat.div_busy) begin
          state_next = (k == STAT_ISTD) ? ST_SQ_GO : ST_EMIT;
        end
      end
      ST_SQ_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (!stat.sqrt_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (k == STAT_COUNT) begin
          cmd.val_sel = VS_COUNT;
        end else if (k == STAT_ISTD) begin
          cmd.val_sel = VS_ROOT;
        end else if (k inside {[STAT_CMIN0:STAT_CMEAN0-1]}) begin
          cmd.val_sel = VS_CHAN;
        end else begin
          cmd.val_sel = VS_QUOT;
        end
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (k == STAT_LAST) begin
            state_next = ST_IDLE;
          end else begin
            k_next     = k + IDX_W'(1);
            state_next = ST_STAT;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/image_statistics_accumulator_unit.sv
// ----------------------------------------------------------------------------
// image_statistics_accumulator_unit
// Frame statistics over a pixel stream: count, intensity, rgb and covariance.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready), one beat per pixel, and the
// block takes one beat per cycle while a frame streams in. The beat with
// last_pixel set closes the frame; after it in_ready drops until the run of
// twenty statistics has been loaded into the output register.
// The run is computed by one shift-add multiplier, one restoring divider
// and a square root. In both modes the run makes thirteen divider passes,
// which take most of its time.
// Each statistic waits in the output register until out_ready; a stalled
// receiver simply holds the sequencer. While the final statistic waits, the
// next frame's pixels are already accepted.
// The cfg channel writes channel_mode and is always ready; write it only
// between frames. Reset (rst, synchronous) selects rgb mode and arms the
// next pixel to start a new frame.
// ----------------------------------------------------------------------------
module image_statistics_accumulator_unit import isa_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  input  logic signed [15:0]      scalar_value,
  input  logic                    last_pixel,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        stat_index,
  output logic signed [VAL_W-1:0] stat_value,
  output logic                    last_stat
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  isa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_pixel (last_pixel),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  isa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .scalar_value (scalar_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .stat_index   (stat_index),
    .stat_value   (stat_value),
    .last_stat    (last_stat)
  );

  // closing beat of a frame starts the run
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_pixel |=> !in_ready)
    else $error("input still ready after last pixel");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_stat |-> stat_index == STAT_LAST)
    else $error("last_stat on wrong statistic");

  // mid-run statistics never coexist with pixel intake
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_stat |-> !in_ready)
    else $error("pixel intake open during a run");

endmodule
